// ===== hdl/dbm_pkg.sv =====
package dbm_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ModeW = 2;
  localparam int unsigned ColorW = 24;
  localparam int unsigned PressW = 32;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_BLINK_TICKS = CfgIdxW'(1);

  localparam logic [CfgDataW-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CfgDataW-1:0] BLINK_RESET = 16'd500;

  localparam logic [ColorW-1:0] COLOR_OFF = 24'h000000;
  localparam logic [ColorW-1:0] COLOR_BLUE = 24'h0000FF;
  localparam logic [ColorW-1:0] COLOR_GREEN = 24'h00FF00;

  localparam logic [ModeW-1:0] MODE_BLINK = 2'd0;
  localparam logic [ModeW-1:0] MODE_GREEN = 2'd1;

  typedef struct packed {
    logic [PressW-1:0] press_total;
    logic [ColorW-1:0] led_color;
    logic [ModeW-1:0] led_mode;
    logic valid_press;
  } result_t;

endpackage

// ===== hdl/debounced_button_mode_led_controller.sv =====
// An accepted beat is held in the input register, its result in the result register.
// Throughput: one beat per cycle without master-side backpressure; input register,
// single-pass update, result register. Backpressure on the master side stalls both
// stages; the input stays open while the result register is free or being drained.
// Reset (rst_ni low, async): button released, mode 0 with LED off, counters cleared,
// debounce_ticks = 50, blink_ticks = 500.
module debounced_button_mode_led_controller #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned LAST_MODE = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dbm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dbm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dbm_pkg::InDataW-1:0]   s_axis_tdata,  // [0] button_level
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] valid_press, [2:1] led_mode, [26:3] led_color, [58:27] press_total
  output logic [dbm_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned ResW = $bits(dbm_pkg::result_t);

  logic [dbm_pkg::CfgDataW-1:0] debounce_q, blink_q;
  logic                         in_valid_q;
  logic                         in_level_q;
  logic                         out_valid_q;
  dbm_pkg::result_t             out_q;
  dbm_pkg::result_t             result;
  logic                         advance;
  logic                         press;

  assign cfg_ready_o = 1'b1;
  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dbm_pkg::DEBOUNCE_RESET;
      blink_q <= dbm_pkg::BLINK_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dbm_pkg::CFG_DEBOUNCE_TICKS: debounce_q <= cfg_data_i;
        dbm_pkg::CFG_BLINK_TICKS:    blink_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_level_q <= s_axis_tdata[0];
    end
    if (advance) begin
      out_q <= result;
    end
  end

  dbm_debounce #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_debounce (
    .clk_i,
    .rst_ni,
    .en_i            (advance),
    .level_i         (in_level_q),
    .debounce_ticks_i(debounce_q),
    .press_o         (press)
  );

  dbm_mode_led #(
    .TIMER_WIDTH(TIMER_WIDTH),
    .LAST_MODE  (LAST_MODE)
  ) u_mode_led (
    .clk_i,
    .rst_ni,
    .en_i         (advance),
    .press_i      (press && advance),
    .blink_ticks_i(blink_q),
    .result_o     (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {{(dbm_pkg::OutDataW - ResW){1'b0}}, out_q};

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_valid_q |-> advance)
    else $error("stage stalled with free result register");

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after advance");

endmodule

// ===== hdl/dbm_debounce.sv =====
module dbm_debounce #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             level_i,
  input  logic [dbm_pkg::CfgDataW-1:0]     debounce_ticks_i,
  output logic                             press_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > dbm_pkg::CfgDataW) ? TIMER_WIDTH
                                                                  : dbm_pkg::CfgDataW;

  logic                   raw_prev_q, raw_prev_d;
  logic                   deb_q, deb_d;
  logic [TIMER_WIDTH-1:0] stable_q, stable_d;
  logic                   accept;

  always_comb begin
    if (level_i != raw_prev_q) begin
      stable_d = '0;
    end else if (stable_q == {TIMER_WIDTH{1'b1}}) begin
      stable_d = stable_q;
    end else begin
      stable_d = stable_q + TIMER_WIDTH'(1);
    end
    raw_prev_d = level_i;
    accept = (CmpW'(stable_d) >= CmpW'(debounce_ticks_i)) && (level_i != deb_q);
    deb_d = accept ? level_i : deb_q;
    press_o = accept && level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_prev_q <= 1'b1;
      deb_q <= 1'b1;
      stable_q <= '0;
    end else if (en_i) begin
      raw_prev_q <= raw_prev_d;
      deb_q <= deb_d;
      stable_q <= stable_d;
    end
  end

  a_press_sets_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && press_o |=> deb_q && !$past(deb_q))
    else $error("press without debounced release");

endmodule

// ===== hdl/dbm_mode_led.sv =====
module dbm_mode_led #(
  parameter int unsigned TIMER_WIDTH = 16,
  parameter int unsigned LAST_MODE = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         press_i,
  input  logic [dbm_pkg::CfgDataW-1:0] blink_ticks_i,
  output dbm_pkg::result_t             result_o
);

  localparam int unsigned CmpW = (TIMER_WIDTH > dbm_pkg::CfgDataW) ? TIMER_WIDTH
                                                                  : dbm_pkg::CfgDataW;

  logic [dbm_pkg::ModeW-1:0]  mode_q, mode_d;
  logic                       blink_on_q, blink_on_d;
  logic [TIMER_WIDTH-1:0]     blink_cnt_q, blink_cnt_d;
  logic [dbm_pkg::PressW-1:0] press_cnt_q, press_cnt_d;
  logic [dbm_pkg::ModeW:0]    mode_inc;

  always_comb begin
    blink_cnt_d = (blink_cnt_q == {TIMER_WIDTH{1'b1}}) ? blink_cnt_q
                                                       : blink_cnt_q + TIMER_WIDTH'(1);
    blink_on_d = blink_on_q;
    mode_d = mode_q;
    press_cnt_d = press_cnt_q;
    mode_inc = {1'b0, mode_q} + 3'd1;
    if (press_i) begin
      press_cnt_d = press_cnt_q + dbm_pkg::PressW'(1);
      mode_d = (mode_inc > 3'(LAST_MODE)) ? dbm_pkg::MODE_BLINK : mode_inc[1:0];
      if (mode_d == dbm_pkg::MODE_BLINK) begin
        blink_cnt_d = '0;
        blink_on_d = 1'b0;
      end
    end
    if (mode_d == dbm_pkg::MODE_BLINK && CmpW'(blink_cnt_d) >= CmpW'(blink_ticks_i)) begin
      blink_cnt_d = '0;
      blink_on_d = !blink_on_d;
    end

    result_o.valid_press = press_i;
    result_o.led_mode = mode_d;
    result_o.press_total = press_cnt_d;
    if (mode_d == dbm_pkg::MODE_BLINK) begin
      result_o.led_color = blink_on_d ? dbm_pkg::COLOR_BLUE : dbm_pkg::COLOR_OFF;
    end else if (mode_d == dbm_pkg::MODE_GREEN) begin
      result_o.led_color = dbm_pkg::COLOR_GREEN;
    end else begin
      result_o.led_color = dbm_pkg::COLOR_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dbm_pkg::MODE_BLINK;
      blink_on_q <= 1'b0;
      blink_cnt_q <= '0;
      press_cnt_q <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      blink_on_q <= blink_on_d;
      blink_cnt_q <= blink_cnt_d;
      press_cnt_q <= press_cnt_d;
    end
  end

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(mode_q) <= LAST_MODE)
    else $error("mode beyond last");

  a_press_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && press_i |=> press_cnt_q == $past(press_cnt_q) + dbm_pkg::PressW'(1))
    else $error("press count did not step");

  a_hold_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(mode_q) && $stable(press_cnt_q))
    else $error("state moved without a beat");

endmodule
